### hw/rtl/vat_pkg.sv
// ----------------------------------------------------------------------------
// vat_pkg: shared types and constants for the vertex affine transform
// Payload structs, register and mode codes, CORDIC arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package vat_pkg;

  // Coordinate format: signed Q16.16
  localparam int COORD_WIDTH = 32;

  // CORDIC iteration count (default) and table depth
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int CORDIC_STEPS_MAX = 24;

  // Sine / cosine format: signed Q1.16
  localparam int TRIG_WIDTH = 18;
  localparam logic signed [TRIG_WIDTH-1:0] TRIG_ONE  = 18'sd65536;
  localparam logic signed [TRIG_WIDTH-1:0] TRIG_ZERO = 18'sd0;

  // Configuration port
  localparam int CFG_DATA_WIDTH  = 32;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int MODE_WIDTH      = 2;
  localparam int AXIS_WIDTH      = 2;
  localparam int ANGLE_WIDTH     = 16;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MODE   = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_AXIS   = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ANGLE  = 2'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_AMOUNT = 2'd3;

  localparam logic [MODE_WIDTH-1:0] MODE_ROTATE    = 2'd0;
  localparam logic [MODE_WIDTH-1:0] MODE_TRANSLATE = 2'd1;
  localparam logic [MODE_WIDTH-1:0] MODE_SCALE     = 2'd2;

  localparam logic [AXIS_WIDTH-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_WIDTH-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_WIDTH-1:0] AXIS_Z = 2'd2;

  // Register stages from input register to output register
  localparam int PIPE_DEPTH = 7;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x_in;
    logic signed [COORD_WIDTH-1:0] y_in;
    logic signed [COORD_WIDTH-1:0] z_in;
  } vertex_in_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x_out;
    logic signed [COORD_WIDTH-1:0] y_out;
    logic signed [COORD_WIDTH-1:0] z_out;
  } vertex_out_t;

  // Status from the sine/cosine generator
  typedef struct packed {
    logic                         busy;
    logic signed [TRIG_WIDTH-1:0] cos_val;
    logic signed [TRIG_WIDTH-1:0] sin_val;
  } trig_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] cordic_atan(input logic [4:0] idx);
    logic [31:0] val;
    unique case (idx)
      5'd0:    val = 32'h20000000;
      5'd1:    val = 32'h12E4051E;
      5'd2:    val = 32'h09FB385B;
      5'd3:    val = 32'h051111D4;
      5'd4:    val = 32'h028B0D43;
      5'd5:    val = 32'h0145D7E1;
      5'd6:    val = 32'h00A2F61E;
      5'd7:    val = 32'h00517C55;
      5'd8:    val = 32'h0028BE53;
      5'd9:    val = 32'h00145F2F;
      5'd10:   val = 32'h000A2F98;
      5'd11:   val = 32'h000517CC;
      5'd12:   val = 32'h00028BE6;
      5'd13:   val = 32'h000145F3;
      5'd14:   val = 32'h0000A2FA;
      5'd15:   val = 32'h0000517D;
      5'd16:   val = 32'h000028BE;
      5'd17:   val = 32'h0000145F;
      5'd18:   val = 32'h00000A30;
      5'd19:   val = 32'h00000518;
      5'd20:   val = 32'h0000028C;
      5'd21:   val = 32'h00000146;
      5'd22:   val = 32'h000000A3;
      5'd23:   val = 32'h00000051;
      default: val = 32'h00000000;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/vat_cordic.sv
// ----------------------------------------------------------------------------
// vat_cordic: iterative sine/cosine generator
// Rotation-mode CORDIC, one iteration per cycle, started by an angle write.
// Quadrant folding up front, rounding to Q1.16 and clamping in a final cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module vat_cordic #(
  parameter int CORDIC_STEPS = vat_pkg::CORDIC_STEPS_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  start,
  input  wire  [vat_pkg::ANGLE_WIDTH-1:0]      angle,
  output vat_pkg::trig_t                       trig
);

  localparam int CNT_W = $clog2(CORDIC_STEPS + 1);
  localparam int XW    = 34;   // x/y datapath, Q2.30 plus headroom
  localparam int ZW    = 33;   // angle accumulator, 2^32 per turn
  localparam int AW    = vat_pkg::ANGLE_WIDTH + 1;
  localparam int TW    = vat_pkg::TRIG_WIDTH;

  localparam logic signed [XW-1:0] K_Q30   = 34'sd652032874;
  localparam logic signed [XW-1:0] RND_Q14 = 34'sd8192;
  localparam logic signed [AW-1:0] HALF    = 17'sd32768;
  localparam logic signed [AW-1:0] QUARTER = 17'sd16384;
  localparam logic signed [XW-1:0] C_ONE   = 34'sd65536;

  logic                    busy_r, busy_nxt;
  logic [CNT_W-1:0]        step_r, step_nxt;
  logic signed [XW-1:0]    x_r, x_nxt;
  logic signed [XW-1:0]    y_r, y_nxt;
  logic signed [ZW-1:0]    z_r, z_nxt;
  logic                    flip_r, flip_nxt;
  logic signed [TW-1:0]    cos_r, cos_nxt;
  logic signed [TW-1:0]    sin_r, sin_nxt;

  logic signed [AW-1:0]    ang_s;
  logic signed [AW-1:0]    ang_fold;
  logic                    fold;
  logic signed [XW-1:0]    x_sh, y_sh;
  logic signed [ZW-1:0]    atan_s;
  logic signed [XW-1:0]    c_rnd, s_rnd;
  logic signed [TW-1:0]    c_fin, s_fin;

  // Clamp a Q2.30 value already rounded and shifted to Q1.16
  function automatic logic signed [TW-1:0] clamp_q16(input logic signed [XW-1:0] v);
    logic signed [TW-1:0] r;
    if (v > C_ONE) begin
      r = TW'(C_ONE);
    end else if (v < -C_ONE) begin
      r = TW'(-C_ONE);
    end else begin
      r = TW'(v);
    end
    return r;
  endfunction

  // Fold angle into [-quarter, quarter]; a folded angle negates the result
  always_comb begin
    ang_s = {angle[vat_pkg::ANGLE_WIDTH-1], angle};
    fold  = 1'b0;
    ang_fold = ang_s;
    if (ang_s > QUARTER) begin
      ang_fold = ang_s - HALF;
      fold     = 1'b1;
    end else if (ang_s < -QUARTER) begin
      ang_fold = ang_s + HALF;
      fold     = 1'b1;
    end
  end

  // One micro-rotation and the final rounding
  always_comb begin
    x_sh   = x_r >>> step_r;
    y_sh   = y_r >>> step_r;
    atan_s = $signed({1'b0, vat_pkg::cordic_atan(5'(step_r))});
    c_rnd  = (x_r + RND_Q14) >>> 14;
    s_rnd  = (y_r + RND_Q14) >>> 14;
    c_fin  = flip_r ? -clamp_q16(c_rnd) : clamp_q16(c_rnd);
    s_fin  = flip_r ? -clamp_q16(s_rnd) : clamp_q16(s_rnd);
  end

  // Sequencer: load, iterate, finish
  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    flip_nxt = flip_r;
    cos_nxt  = cos_r;
    sin_nxt  = sin_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      x_nxt    = K_Q30;
      y_nxt    = '0;
      z_nxt    = {ang_fold, 16'b0};
      flip_nxt = fold;
    end else if (busy_r) begin
      if (step_r == CNT_W'(CORDIC_STEPS)) begin
        busy_nxt = 1'b0;
        cos_nxt  = c_fin;
        sin_nxt  = s_fin;
      end else begin
        step_nxt = step_r + 1'b1;
        if (!z_r[ZW-1]) begin
          x_nxt = x_r - y_sh;
          y_nxt = y_r + x_sh;
          z_nxt = z_r - atan_s;
        end else begin
          x_nxt = x_r + y_sh;
          y_nxt = y_r - x_sh;
          z_nxt = z_r + atan_s;
        end
      end
    end
  end

  // Control and held results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
      cos_r  <= vat_pkg::TRIG_ONE;
      sin_r  <= vat_pkg::TRIG_ZERO;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
      cos_r  <= cos_nxt;
      sin_r  <= sin_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    flip_r <= flip_nxt;
  end

  assign trig.busy    = busy_r;
  assign trig.cos_val = cos_r;
  assign trig.sin_val = sin_r;

endmodule

`default_nettype wire

### hw/rtl/vertex_affine_transform.sv
// Throughput: one vertex per cycle unless the output stalls or the CORDIC runs;
// stages hold independently, so bubbles close up. An angle write starts the
// iterative CORDIC, and in_ready is low while it runs; that single shared unit
// holds off all input while it runs.
// Synchronous active-low reset empties the pipeline, clears the mode, axis and
// amount registers to zero and sets cosine to one and sine to zero.
// ----------------------------------------------------------------------------
// vertex_affine_transform: streaming rotate / translate / scale of vertices
// Seven-stage pipeline: input reg, multiply, sum/magnitude, saturate/quotient
// high part, remainder, quotient low part, output select and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module vertex_affine_transform #(
  parameter int CORDIC_STEPS = vat_pkg::CORDIC_STEPS_DEF
) (
  input  wire                                     clk,
  input  wire                                     rst_n,
  input  wire                                     in_valid,
  output logic                                    in_ready,
  input  vat_pkg::vertex_in_t                     in_data,
  output logic                                    out_valid,
  input  wire                                     out_ready,
  output vat_pkg::vertex_out_t                    out_data,
  input  wire                                     cfg_we,
  input  wire  [vat_pkg::CFG_INDEX_WIDTH-1:0]     cfg_index,
  input  wire  [vat_pkg::CFG_DATA_WIDTH-1:0]      cfg_wdata
);

  localparam int CW   = vat_pkg::COORD_WIDTH;
  localparam int TW   = vat_pkg::TRIG_WIDTH;
  localparam int DW   = vat_pkg::CFG_DATA_WIDTH;
  localparam int RP_W = CW + TW;        // rotation product
  localparam int RS_W = RP_W + 1;       // rotation product sum
  localparam int TS_W = CW + 1;         // translate sum
  localparam int SP_W = CW + DW;        // scale product
  // Scale divide by 100: magnitudes at or above 2^SM_W saturate anyway
  localparam int SM_W = CW + 6;
  localparam int L_W  = 20;
  localparam int H_W  = SM_W - L_W;
  localparam int QH_W = CW - L_W;
  localparam int RH_W = 7;
  localparam int V_W  = RH_W + L_W;
  // Reciprocals of 100: ceil(2^25/100) for H, ceil(2^34/100) for the low part
  localparam int R1_W  = 19;
  localparam int R1_SH = 25;
  localparam int R2_W  = 28;
  localparam int R2_SH = 34;
  localparam int P1_W  = H_W + R1_W;
  localparam int P2_W  = V_W + R2_W;
  localparam logic [R1_W-1:0] RECIP1 = 19'd335545;
  localparam logic [R2_W-1:0] RECIP2 = 28'd171798692;
  localparam logic [H_W-1:0]  DIV100 = 18'd100;
  localparam logic [SP_W-1:0] HALF_DIV     = SP_W'(50);
  localparam logic [SP_W-1:0] HALF_DIV_INC = SP_W'(51);

  localparam logic signed [RS_W-1:0] ROT_RND = RS_W'(32768);
  localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};

  // ---------------- helpers ----------------
  function automatic logic signed [CW-1:0] sat_rot(input logic signed [RS_W-1:0] v);
    logic signed [RS_W-1:0] sh;
    logic signed [CW-1:0]   r;
    sh = v >>> 16;
    if (!sh[RS_W-1] && (|sh[RS_W-2:CW-1])) begin
      r = COORD_MAX;
    end else if (sh[RS_W-1] && !(&sh[RS_W-2:CW-1])) begin
      r = COORD_MIN;
    end else begin
      r = sh[CW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [CW-1:0] sat_sum(input logic signed [TS_W-1:0] v);
    logic signed [CW-1:0] r;
    if (v[TS_W-1] != v[TS_W-2]) begin
      r = v[TS_W-1] ? COORD_MIN : COORD_MAX;
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [CW-1:0] sat_scale(input logic big, input logic neg,
                                                     input logic [CW-1:0] q);
    logic signed [CW-1:0] r;
    if (big) begin
      r = neg ? COORD_MIN : COORD_MAX;
    end else if (!neg) begin
      r = q[CW-1] ? COORD_MAX : $signed(q);
    end else if (q[CW-1] && (|q[CW-2:0])) begin
      r = COORD_MIN;
    end else begin
      r = $signed(~q + 1'b1);
    end
    return r;
  endfunction

  // ---------------- configuration ----------------
  logic [vat_pkg::MODE_WIDTH-1:0] mode_r;
  logic [vat_pkg::AXIS_WIDTH-1:0] axis_r;
  logic signed [DW-1:0]           amount_r;
  logic                           angle_we;
  vat_pkg::trig_t                 trig;

  assign angle_we = cfg_we && (cfg_index == vat_pkg::REG_ANGLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= '0;
      axis_r   <= '0;
      amount_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vat_pkg::REG_MODE:   mode_r   <= cfg_wdata[vat_pkg::MODE_WIDTH-1:0];
        vat_pkg::REG_AXIS:   axis_r   <= cfg_wdata[vat_pkg::AXIS_WIDTH-1:0];
        vat_pkg::REG_AMOUNT: amount_r <= $signed(cfg_wdata);
        default: ;  // angle goes to the CORDIC
      endcase
    end
  end

  vat_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_vat_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (angle_we),
    .angle (cfg_wdata[vat_pkg::ANGLE_WIDTH-1:0]),
    .trig  (trig)
  );

  logic signed [TW-1:0] cos_s, sin_s;
  assign cos_s = trig.cos_val;
  assign sin_s = trig.sin_val;

  // ---------------- stage registers ----------------
  logic                 s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r, s6_v_r, out_valid_r;
  logic                 en1, en2, en3, en4, en5, en6, en7;

  logic signed [CW-1:0]   s1_c_r [3];

  logic signed [CW-1:0]   s2_c_r [3];
  logic signed [RP_W-1:0] s2_ca_r, s2_sb_r, s2_cb_r, s2_sa_r;
  logic signed [SP_W-1:0] s2_sp_r [3];
  logic signed [TS_W-1:0] s2_ts_r;

  logic signed [CW-1:0]   s3_c_r [3];
  logic signed [RS_W-1:0] s3_pa_r, s3_pb_r;
  logic signed [CW-1:0]   s3_ts_r;
  logic                   s3_neg_r [3];
  logic                   s3_big_r [3];
  logic [SM_W-1:0]        s3_m_r   [3];

  logic signed [CW-1:0]   s4_c_r   [3];
  logic                   s4_neg_r [3];
  logic                   s4_big_r [3];
  logic [H_W-1:0]         s4_h_r   [3];
  logic [L_W-1:0]         s4_l_r   [3];
  logic [QH_W-1:0]        s4_qh_r  [3];

  logic signed [CW-1:0]   s5_c_r   [3];
  logic                   s5_neg_r [3];
  logic                   s5_big_r [3];
  logic [QH_W-1:0]        s5_qh_r  [3];
  logic [V_W-1:0]         s5_rv_r  [3];

  logic signed [CW-1:0]   s6_c_r   [3];
  logic                   s6_neg_r [3];
  logic                   s6_big_r [3];
  logic [QH_W-1:0]        s6_qh_r  [3];
  logic [L_W-1:0]         s6_ql_r  [3];

  vat_pkg::vertex_out_t   out_data_r;

  // Per-stage advance: a stage moves when empty or when the next one moves
  assign en7 = !out_valid_r || out_ready;
  assign en6 = !s6_v_r || en7;
  assign en5 = !s5_v_r || en6;
  assign en4 = !s4_v_r || en5;
  assign en3 = !s3_v_r || en4;
  assign en2 = !s2_v_r || en3;
  assign en1 = !s1_v_r || en2;

  assign in_ready = en1 && !trig.busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      s5_v_r      <= 1'b0;
      s6_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1) s1_v_r      <= in_valid && in_ready;
      if (en2) s2_v_r      <= s1_v_r;
      if (en3) s3_v_r      <= s2_v_r;
      if (en4) s4_v_r      <= s3_v_r;
      if (en5) s5_v_r      <= s4_v_r;
      if (en6) s6_v_r      <= s5_v_r;
      if (en7) out_valid_r <= s6_v_r;
    end
  end

  // ---------------- stage 1: input register ----------------
  always_ff @(posedge clk) begin
    if (en1) begin
      s1_c_r[0] <= in_data.x_in;
      s1_c_r[1] <= in_data.y_in;
      s1_c_r[2] <= in_data.z_in;
    end
  end

  // ---------------- stage 2: multiplies ----------------
  logic signed [CW-1:0]   op_a, op_b, op_t;

  // Rotation pair and translate target by axis
  always_comb begin
    op_a = s1_c_r[1];
    op_b = s1_c_r[2];
    op_t = s1_c_r[0];
    unique case (axis_r)
      vat_pkg::AXIS_X: begin
        op_a = s1_c_r[1];
        op_b = s1_c_r[2];
        op_t = s1_c_r[0];
      end
      vat_pkg::AXIS_Y: begin
        op_a = s1_c_r[2];
        op_b = s1_c_r[0];
        op_t = s1_c_r[1];
      end
      vat_pkg::AXIS_Z: begin
        op_a = s1_c_r[0];
        op_b = s1_c_r[1];
        op_t = s1_c_r[2];
      end
      default: ;  // unused axis: vertex passes, operands unused
    endcase
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_ca_r <= cos_s * op_a;
      s2_sb_r <= sin_s * op_b;
      s2_cb_r <= cos_s * op_b;
      s2_sa_r <= sin_s * op_a;
      s2_ts_r <= TS_W'(op_t) + TS_W'(amount_r);
      for (int k = 0; k < 3; k++) begin
        s2_c_r[k]  <= s1_c_r[k];
        s2_sp_r[k] <= s1_c_r[k] * amount_r;
      end
    end
  end

  // ---------------- stage 3: sums, magnitudes ----------------
  logic [SP_W-1:0] mag_base [3];
  logic [SP_W-1:0] mag_rnd  [3];

  // |p| + 50, with the negate folded into the add
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag_base[k] = s2_sp_r[k][SP_W-1] ? ~s2_sp_r[k] : s2_sp_r[k];
      mag_rnd[k]  = mag_base[k] + (s2_sp_r[k][SP_W-1] ? HALF_DIV_INC : HALF_DIV);
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_pa_r <= s2_ca_r - s2_sb_r + ROT_RND;
      s3_pb_r <= s2_cb_r + s2_sa_r + ROT_RND;
      s3_ts_r <= sat_sum(s2_ts_r);
      for (int k = 0; k < 3; k++) begin
        s3_c_r[k]   <= s2_c_r[k];
        s3_neg_r[k] <= s2_sp_r[k][SP_W-1];
        s3_big_r[k] <= |mag_rnd[k][SP_W-1:SM_W];
        s3_m_r[k]   <= mag_rnd[k][SM_W-1:0];
      end
    end
  end

  // ---------------- stage 4: rotate/translate result, quotient high ----------------
  logic signed [CW-1:0] rot_a, rot_b;
  logic signed [CW-1:0] res4 [3];
  logic [P1_W-1:0]      qh_prod [3];

  always_comb begin
    rot_a = sat_rot(s3_pa_r);
    rot_b = sat_rot(s3_pb_r);
    for (int k = 0; k < 3; k++) begin
      res4[k] = s3_c_r[k];
    end
    unique case (mode_r)
      vat_pkg::MODE_ROTATE: begin
        unique case (axis_r)
          vat_pkg::AXIS_X: begin
            res4[1] = rot_a;
            res4[2] = rot_b;
          end
          vat_pkg::AXIS_Y: begin
            res4[2] = rot_a;
            res4[0] = rot_b;
          end
          vat_pkg::AXIS_Z: begin
            res4[0] = rot_a;
            res4[1] = rot_b;
          end
          default: ;
        endcase
      end
      vat_pkg::MODE_TRANSLATE: begin
        unique case (axis_r)
          vat_pkg::AXIS_X: res4[0] = s3_ts_r;
          vat_pkg::AXIS_Y: res4[1] = s3_ts_r;
          vat_pkg::AXIS_Z: res4[2] = s3_ts_r;
          default: ;
        endcase
      end
      default: ;  // scale picks its result at the output; unused mode passes
    endcase
    for (int k = 0; k < 3; k++) begin
      qh_prod[k] = P1_W'(s3_m_r[k][SM_W-1:L_W]) * P1_W'(RECIP1);
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      for (int k = 0; k < 3; k++) begin
        s4_c_r[k]   <= res4[k];
        s4_neg_r[k] <= s3_neg_r[k];
        s4_big_r[k] <= s3_big_r[k];
        s4_h_r[k]   <= s3_m_r[k][SM_W-1:L_W];
        s4_l_r[k]   <= s3_m_r[k][L_W-1:0];
        s4_qh_r[k]  <= qh_prod[k][R1_SH +: QH_W];
      end
    end
  end

  // ---------------- stage 5: remainder of the high part ----------------
  logic [H_W-1:0] rem_h [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rem_h[k] = s4_h_r[k] - H_W'(s4_qh_r[k]) * DIV100;
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      for (int k = 0; k < 3; k++) begin
        s5_c_r[k]   <= s4_c_r[k];
        s5_neg_r[k] <= s4_neg_r[k];
        s5_big_r[k] <= s4_big_r[k];
        s5_qh_r[k]  <= s4_qh_r[k];
        s5_rv_r[k]  <= {rem_h[k][RH_W-1:0], s4_l_r[k]};
      end
    end
  end

  // ---------------- stage 6: quotient low part ----------------
  logic [P2_W-1:0] ql_prod [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ql_prod[k] = P2_W'(s5_rv_r[k]) * P2_W'(RECIP2);
    end
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      for (int k = 0; k < 3; k++) begin
        s6_c_r[k]   <= s5_c_r[k];
        s6_neg_r[k] <= s5_neg_r[k];
        s6_big_r[k] <= s5_big_r[k];
        s6_qh_r[k]  <= s5_qh_r[k];
        s6_ql_r[k]  <= ql_prod[k][R2_SH +: L_W];
      end
    end
  end

  // ---------------- stage 7: output register ----------------
  logic signed [CW-1:0] res7 [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (mode_r == vat_pkg::MODE_SCALE) begin
        res7[k] = sat_scale(s6_big_r[k], s6_neg_r[k], {s6_qh_r[k], s6_ql_r[k]});
      end else begin
        res7[k] = s6_c_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en7) begin
      out_data_r.x_out <= res7[0];
      out_data_r.y_out <= res7[1];
      out_data_r.z_out <= res7[2];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

### hw/rtl/vat_checker.sv
// ----------------------------------------------------------------------------
// vat_checker: port-level checks for vertex_affine_transform
// Tracks items in flight; checks output hold, reset, CORDIC blocking, bounds.
// ----------------------------------------------------------------------------
`default_nettype none

module vat_checker (
  input wire                                  clk,
  input wire                                  rst_n,
  input wire                                  in_valid,
  input wire                                  in_ready,
  input wire                                  out_valid,
  input wire                                  out_ready,
  input vat_pkg::vertex_out_t                 out_data,
  input wire                                  cfg_we,
  input wire [vat_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index
);

  localparam int CNT_W = $clog2(vat_pkg::PIPE_DEPTH + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Items accepted but not yet delivered
  always_comb begin
    cnt_nxt = cnt_r;
    if (in_acc && !out_acc) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!in_acc && out_acc) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid after reset");

  // New angle blocks input while sine/cosine are recomputed
  a_angle_block: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && (cfg_index == vat_pkg::REG_ANGLE) |=> !in_ready)
    else $error("input accepted during CORDIC run");

  // Never more items in flight than pipeline stages
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(vat_pkg::PIPE_DEPTH))
    else $error("more items in flight than stages");

  // No result without an accepted item
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cnt_r != '0)
    else $error("result with no item in flight");

endmodule

bind vertex_affine_transform vat_checker u_vat_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .cfg_we    (cfg_we),
  .cfg_index (cfg_index)
);

`default_nettype wire
